@@ hdl/nnis_pkg.sv @@
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, constants and helpers of the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int ROW_LIMIT  = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SIZE_W     = 13;
	localparam int SCALE_W    = 16;
	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W      = SCALE_W + 1;
	localparam int PROD_W     = SUM_W + SIZE_W;
	localparam int CNT_W      = $clog2(PROD_W);

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALED_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALED_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT   = 3'd7;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel;
	} item_t;

	typedef struct packed {
		logic             accepted;
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             frame_end;
	} result_t;

	// Effective sizes: zeros read as one, oversize values saturate.
	typedef struct packed {
		logic [SIZE_W-1:0]  sw;
		logic [SIZE_W-1:0]  sh;
		logic [SCALE_W-1:0] scw;
		logic [SCALE_W-1:0] sch;
		logic [SCALE_W-1:0] left;
		logic [SCALE_W-1:0] top;
		logic [SIZE_W-1:0]  cw;
		logic [SIZE_W-1:0]  ch;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [COL_W-1:0]   pos;
		logic [SCALE_W-1:0] offset;
		logic [SIZE_W-1:0]  src;
		logic [SCALE_W-1:0] den;
	} map_req_t;

	typedef struct packed {
		logic             done;
		logic [COL_W-1:0] idx;
	} map_res_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] hi);
		if (v == '0)
			return SIZE_W'(1);
		return (v > hi) ? hi : v;
	endfunction

endpackage

@@ hdl/nnis_in_if.sv @@
// ----------------------------------------------------------------------------
// nnis_in_if
// Command channel: push of a source pixel or pull of an output pixel.
// ----------------------------------------------------------------------------
interface nnis_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] pixel_in;

	modport source (output valid, cmd, pixel_in, input ready);
	modport sink (input valid, cmd, pixel_in, output ready);
endinterface

@@ hdl/nnis_out_if.sv @@
// ----------------------------------------------------------------------------
// nnis_out_if
// Result channel: one result beat for every command beat.
// ----------------------------------------------------------------------------
interface nnis_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [31:0] pixel_out;
	logic        row_end;
	logic        frame_end;

	modport source (output valid, accepted, pixel_out, row_end, frame_end, input ready);
	modport sink (input valid, accepted, pixel_out, row_end, frame_end, output ready);
endinterface

@@ hdl/nearest_neighbour_image_scaler.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler
// Nearest-neighbour scaler with crop window over a one-row line store.
// ----------------------------------------------------------------------------
// Every command beat gives exactly one result beat, in order. A push passes
// through the command queue and the execution stage. For a pull that produces
// a pixel, the column index comes from a serial divider that yields one
// quotient bit per cycle over 30 bits, followed by one registered line store
// read. The last pixel of an output row also maps the next source row through
// the same divider, and so does the first command after a configuration write.
// Refused pulls skip the divider and take the same path as pushes. The line
// store is not cleared after reset. The user must write configuration only
// while the block is idle; the block itself does not enforce it. Every write
// restarts the frame.
module nearest_neighbour_image_scaler (
	input  logic                            clk,
	input  logic                            arst_n,
	nnis_in_if.sink                         req,
	nnis_out_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nnis_pkg::*;

	logic [SIZE_W-1:0]  src_w_q;
	logic [SIZE_W-1:0]  src_h_q;
	logic [SCALE_W-1:0] scl_w_q;
	logic [SCALE_W-1:0] scl_h_q;
	logic [SCALE_W-1:0] left_q;
	logic [SCALE_W-1:0] top_q;
	logic [SIZE_W-1:0]  crop_w_q;
	logic [SIZE_W-1:0]  crop_h_q;

	cfg_t  cfg;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= SIZE_W'(1);
			src_h_q  <= SIZE_W'(1);
			scl_w_q  <= SCALE_W'(1);
			scl_h_q  <= SCALE_W'(1);
			left_q   <= '0;
			top_q    <= '0;
			crop_w_q <= SIZE_W'(1);
			crop_h_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  src_w_q  <= cfg_data[SIZE_W-1:0];
				REG_SOURCE_HEIGHT: src_h_q  <= cfg_data[SIZE_W-1:0];
				REG_SCALED_WIDTH:  scl_w_q  <= cfg_data;
				REG_SCALED_HEIGHT: scl_h_q  <= cfg_data;
				REG_CROP_LEFT:     left_q   <= cfg_data;
				REG_CROP_TOP:      top_q    <= cfg_data;
				REG_CROP_WIDTH:    crop_w_q <= cfg_data[SIZE_W-1:0];
				REG_CROP_HEIGHT:   crop_h_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.sw   = clamp_size(src_w_q, SIZE_W'(MAX_WIDTH));
		cfg.sh   = clamp_size(src_h_q, SIZE_W'(ROW_LIMIT));
		cfg.scw  = (scl_w_q == '0) ? SCALE_W'(1) : scl_w_q;
		cfg.sch  = (scl_h_q == '0) ? SCALE_W'(1) : scl_h_q;
		cfg.left = left_q;
		cfg.top  = top_q;
		cfg.cw   = clamp_size(crop_w_q, SIZE_W'(ROW_LIMIT));
		cfg.ch   = clamp_size(crop_h_q, SIZE_W'(ROW_LIMIT));
	end

	nnis_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	nnis_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (cfg_we),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

@@ hdl/nnis_front.sv @@
// ----------------------------------------------------------------------------
// nnis_front
// Accepts command beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nnis_front (
	input  logic          clk,
	input  logic          arst_n,
	nnis_in_if.sink       req,
	output logic          q_valid,
	output nnis_pkg::item_t q_item,
	input  logic          q_pop
);
	import nnis_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (fill_q != 2'd0);
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{cmd: req.cmd, pixel: req.pixel_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				fill_q <= fill_q + 2'd1;
			else if (!push && q_pop)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

@@ hdl/nnis_map.sv @@
// ----------------------------------------------------------------------------
// nnis_map
// Index mapper: floor((pos + offset) * src / den), clamped to src - 1.
// One multiply on start, then a restoring divide at one quotient bit a cycle.
// ----------------------------------------------------------------------------
module nnis_map (
	input  logic               clk,
	input  logic               arst_n,
	input  nnis_pkg::map_req_t req,
	output nnis_pkg::map_res_t res
);
	import nnis_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  quo_q;
	logic [SCALE_W-1:0] rem_q;
	logic [SCALE_W-1:0] den_q;
	logic [SIZE_W-1:0]  src_q;
	logic               done_q;
	logic [COL_W-1:0]   idx_q;

	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   trial;
	logic               ge;
	logic [SUM_W-1:0]   diff;
	logic [PROD_W-1:0]  quo_nx;
	logic [SIZE_W-1:0]  src_m1;

	always_comb begin
		sum    = {{(SUM_W-COL_W){1'b0}}, req.pos} + {1'b0, req.offset};
		prod   = {{SIZE_W{1'b0}}, sum} * {{SUM_W{1'b0}}, req.src};
		trial  = {rem_q, prod_q[PROD_W-1]};
		ge     = (trial >= {1'b0, den_q});
		diff   = trial - {1'b0, den_q};
		quo_nx = {quo_q[PROD_W-2:0], ge};
		src_m1 = src_q - SIZE_W'(1);
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= prod;
			den_q  <= (req.den == '0) ? SCALE_W'(1) : req.den;
			src_q  <= req.src;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[PROD_W-2:0], 1'b0};
			rem_q  <= ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
			quo_q  <= quo_nx;
			if (quo_nx >= {{(PROD_W-SIZE_W){1'b0}}, src_q})
				idx_q <= src_m1[COL_W-1:0];
			else
				idx_q <= quo_nx[COL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PROD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign res.done = done_q;
	assign res.idx  = idx_q;

endmodule

@@ hdl/nnis_back.sv @@
// ----------------------------------------------------------------------------
// nnis_back
// Executes queued commands: line store writes on push, sampling on pull,
// frame alignment, and the registered result beat.
// ----------------------------------------------------------------------------
module nnis_back (
	input  logic           clk,
	input  logic           arst_n,
	input  nnis_pkg::cfg_t cfg,
	input  logic           restart,
	input  logic           q_valid,
	input  nnis_pkg::item_t q_item,
	output logic           q_pop,
	nnis_out_if.source     rsp
);
	import nnis_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COL  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_NROW = 2'd3;

	logic [1:0]       state_q;
	logic [COL_W-1:0] src_col_q;
	logic [COL_W-1:0] src_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [COL_W-1:0] out_row_q;
	logic [COL_W-1:0] needed_q;
	logic             row_loaded_q;
	logic             src_ahead_q;
	logic             out_ahead_q;
	logic             pend_q;
	logic             out_valid_q;
	result_t          out_q;
	logic [PIX_W-1:0] rd_data_q;
	logic [PIX_W-1:0] store_q [MAX_WIDTH];

	map_req_t map_req;
	map_res_t map_res;

	logic take;
	logic src_last_col;
	logic src_last_row;
	logic at_need;
	logic beyond;
	logic push_refuse;
	logic push_store;
	logic pull_refuse;
	logic rend;
	logic fend;

	nnis_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.res    (map_res)
	);

	always_comb begin
		take         = (state_q == ST_IDLE) && !pend_q && q_valid && !out_valid_q && !restart;
		src_last_col = ({1'b0, src_col_q} + SIZE_W'(1)) >= cfg.sw;
		src_last_row = ({1'b0, src_row_q} + SIZE_W'(1)) >= cfg.sh;
		at_need      = src_row_q >= needed_q;
		beyond       = src_row_q > needed_q;
		push_refuse  = src_ahead_q || (!out_ahead_q && at_need && (beyond || row_loaded_q));
		push_store   = !src_ahead_q && !out_ahead_q && at_need && !beyond && !row_loaded_q;
		pull_refuse  = out_ahead_q || !row_loaded_q;
		rend         = ({1'b0, out_col_q} + SIZE_W'(1)) >= cfg.cw;
		fend         = rend && (({1'b0, out_row_q} + SIZE_W'(1)) >= cfg.ch);

		// Row mapping by default; the column mapping is chosen for a pull.
		map_req.start  = 1'b0;
		map_req.pos    = fend ? '0 : out_row_q + COL_W'(1);
		map_req.offset = cfg.top;
		map_req.src    = cfg.sh;
		map_req.den    = cfg.sch;
		if (restart) begin
			map_req.start = 1'b0;
		end else if (state_q == ST_IDLE && pend_q) begin
			map_req.start = 1'b1;
			map_req.pos   = '0;
		end else if (take && q_item.cmd == CMD_PULL && !pull_refuse) begin
			map_req.start  = 1'b1;
			map_req.pos    = out_col_q;
			map_req.offset = cfg.left;
			map_req.src    = cfg.sw;
			map_req.den    = cfg.scw;
		end else if (state_q == ST_RD && rend) begin
			map_req.start = 1'b1;
		end
	end

	assign q_pop = take;

	always_ff @(posedge clk) begin
		if (take && q_item.cmd == CMD_PUSH && push_store)
			store_q[src_col_q] <= q_item.pixel;
		if (state_q == ST_COL && map_res.done)
			rd_data_q <= store_q[map_res.idx];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= '{accepted: (q_item.cmd == CMD_PUSH) && !push_refuse, pixel: '0,
				row_end: 1'b0, frame_end: 1'b0};
		end else if (state_q == ST_RD) begin
			out_q <= '{accepted: 1'b1, pixel: rd_data_q, row_end: rend, frame_end: fend};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			src_col_q    <= '0;
			src_row_q    <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			needed_q     <= '0;
			row_loaded_q <= 1'b0;
			src_ahead_q  <= 1'b0;
			out_ahead_q  <= 1'b0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (restart) begin
			state_q      <= ST_IDLE;
			src_col_q    <= '0;
			src_row_q    <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			row_loaded_q <= 1'b0;
			src_ahead_q  <= 1'b0;
			out_ahead_q  <= 1'b0;
			pend_q       <= 1'b1;
			if (rsp.ready)
				out_valid_q <= 1'b0;
		end else begin
			// A waiting beat blocks both new commands and sampling.
			if (rsp.ready && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pend_q) begin
						pend_q  <= 1'b0;
						state_q <= ST_NROW;
					end else if (take) begin
						if (q_item.cmd == CMD_PUSH) begin
							out_valid_q <= 1'b1;
							if (!push_refuse) begin
								if (!src_last_col) begin
									src_col_q <= src_col_q + COL_W'(1);
								end else begin
									src_col_q <= '0;
									if (!out_ahead_q && src_row_q == needed_q)
										row_loaded_q <= 1'b1;
									if (!src_last_row) begin
										src_row_q <= src_row_q + COL_W'(1);
									end else begin
										src_row_q <= '0;
										if (out_ahead_q)
											out_ahead_q <= 1'b0;
										else
											src_ahead_q <= 1'b1;
									end
								end
							end
						end else if (pull_refuse) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_COL;
						end
					end
				end
				ST_COL: begin
					if (map_res.done)
						state_q <= ST_RD;
				end
				ST_RD: begin
					out_valid_q <= 1'b1;
					if (!rend) begin
						out_col_q <= out_col_q + COL_W'(1);
						state_q   <= ST_IDLE;
					end else begin
						out_col_q <= '0;
						state_q   <= ST_NROW;
						if (!fend) begin
							out_row_q <= out_row_q + COL_W'(1);
						end else begin
							out_row_q    <= '0;
							row_loaded_q <= 1'b0;
							if (src_ahead_q)
								src_ahead_q <= 1'b0;
							else
								out_ahead_q <= 1'b1;
						end
					end
				end
				ST_NROW: begin
					if (map_res.done) begin
						state_q <= ST_IDLE;
						if (map_res.idx != needed_q) begin
							needed_q     <= map_res.idx;
							row_loaded_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.accepted  = out_q.accepted;
	assign rsp.pixel_out = out_q.pixel;
	assign rsp.row_end   = out_q.row_end;
	assign rsp.frame_end = out_q.frame_end;

	// The two frames can never both be ahead of each other.
	a_ahead_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(src_ahead_q && out_ahead_q))
		else $error("source and output both marked ahead");

	// A command is only taken when the result register is free.
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !out_valid_q)
		else $error("command taken while a result is still waiting");

	// The mapper is started only from the idle or sampling states.
	a_map_start: assert property (@(posedge clk) disable iff (!arst_n)
		map_req.start |-> (state_q == ST_IDLE || state_q == ST_RD))
		else $error("mapper started while a mapping is awaited");

	// A result appears only after a taken command or a sampled pixel.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(q_pop) || $past(state_q == ST_RD)))
		else $error("result beat without a command");

endmodule
